[sv/mbps_pkg.sv]
// Shared constants, register codes and types for the masked byte pattern scan.
package mbps_pkg;

    localparam int PatternBytes           = 16;
    localparam int DefaultMaxPatternBytes = 16;
    localparam int DefaultIndexBits       = 32;
    localparam int CfgIndexBits           = 3;
    localparam int CfgDataBits            = 64;
    localparam int AddrBits               = 64;
    localparam int OffsetBits             = 32;
    localparam int MaskBits               = 16;
    localparam int LengthBits             = 5;

    typedef enum logic [CfgIndexBits-1:0] {
        CFG_PATTERN_LOW    = 3'd0,
        CFG_PATTERN_HIGH   = 3'd1,
        CFG_COMPARE_MASK   = 3'd2,
        CFG_PATTERN_LENGTH = 3'd3,
        CFG_REGION_BASE    = 3'd4,
        CFG_RESULT_OFFSET  = 3'd5
    } cfg_index_t;

    typedef struct packed {
        logic advance;
        logic cmp_en;
    } cell_ctrl_t;

endpackage

[sv/mbps_cell.sv]
// One window cell: holds a byte, hands it on, and compares it with its pattern byte.
module mbps_cell
    import mbps_pkg::*;
(
    input  logic       aclk,
    input  cell_ctrl_t ctrl,
    input  logic [7:0] byte_in,
    input  logic [7:0] pat_byte,
    output logic [7:0] byte_out,
    output logic       hit
);

    logic [7:0] byte_reg;

    always_ff @(posedge aclk) begin
        if (ctrl.advance) begin
            byte_reg <= byte_in;
        end
    end

    assign byte_out = byte_reg;
    assign hit      = !ctrl.cmp_en || (byte_reg == pat_byte);

endmodule

[sv/masked_byte_pattern_scan.sv]
// Top level of the masked byte pattern scan: config, cell row, match stage and output skid.
//
// Takes one region byte per cycle with no gaps while s_tready is high. The window is a row
// of MAX_PATTERN_BYTES cells that shift each accepted byte along; all cells compare in
// parallel against the pattern aligned to the configured length. A result passes the cell
// row, the match register and the output register. An output register plus one skid entry
// decouple the sides; s_tready drops only while both hold undelivered results.
module masked_byte_pattern_scan
    import mbps_pkg::*;
#(
    parameter int MAX_PATTERN_BYTES = DefaultMaxPatternBytes,
    parameter int INDEX_BITS        = DefaultIndexBits
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    cfg_we,
    input  logic [CfgIndexBits-1:0] cfg_index,
    input  logic [CfgDataBits-1:0]  cfg_wdata,
    input  logic                    s_tvalid,
    output logic                    s_tready,
    input  logic [7:0]              s_tdata,   // data_byte
    input  logic                    s_tlast,   // last_byte
    output logic                    m_tvalid,
    input  logic                    m_tready,
    output logic [AddrBits-1:0]     m_tdata,   // match_address
    output logic                    m_tuser    // found
);

    localparam int EffMax = (MAX_PATTERN_BYTES < PatternBytes) ? MAX_PATTERN_BYTES
                                                                : PatternBytes;

    // configuration registers
    logic [PatternBytes*8/2-1:0] pat_low_reg;
    logic [PatternBytes*8/2-1:0] pat_high_reg;
    logic [MaskBits-1:0]         mask_reg;
    logic [LengthBits-1:0]       length_reg;
    logic [AddrBits-1:0]         base_reg;
    logic [OffsetBits-1:0]       offset_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pat_low_reg  <= '0;
            pat_high_reg <= '0;
            mask_reg     <= '0;
            length_reg   <= LengthBits'(1);
            base_reg     <= '0;
            offset_reg   <= '0;
        end else if (cfg_we) begin
            unique case (cfg_index_t'(cfg_index))
                CFG_PATTERN_LOW:    pat_low_reg  <= cfg_wdata;
                CFG_PATTERN_HIGH:   pat_high_reg <= cfg_wdata;
                CFG_COMPARE_MASK:   mask_reg     <= cfg_wdata[MaskBits-1:0];
                CFG_PATTERN_LENGTH: length_reg   <= cfg_wdata[LengthBits-1:0];
                CFG_REGION_BASE:    base_reg     <= cfg_wdata;
                CFG_RESULT_OFFSET:  offset_reg   <= cfg_wdata[OffsetBits-1:0];
                default: ;
            endcase
        end
    end

    // derived configuration: effective length, per-cell pattern byte and compare enable, base plus offset
    logic [PatternBytes-1:0][7:0]      pat_bytes;
    logic [LengthBits-1:0]             len_next;
    logic [LengthBits-1:0]             len_reg;
    logic [MAX_PATTERN_BYTES-1:0][7:0] cell_pat_next;
    logic [MAX_PATTERN_BYTES-1:0][7:0] cell_pat_reg;
    logic [MAX_PATTERN_BYTES-1:0]      cell_cmp_next;
    logic [MAX_PATTERN_BYTES-1:0]      cell_cmp_reg;
    logic [AddrBits-1:0]               base_off_next;
    logic [AddrBits-1:0]               base_off_reg;

    assign pat_bytes = {pat_high_reg, pat_low_reg};

    always_comb begin
        logic [3:0] pi;
        len_next = length_reg;
        if (len_next == '0) begin
            len_next = LengthBits'(1);
        end
        if (len_next > LengthBits'(EffMax)) begin
            len_next = LengthBits'(EffMax);
        end
        for (int k = 0; k < MAX_PATTERN_BYTES; k++) begin
            pi = 4'(len_next - LengthBits'(1) - LengthBits'(k % PatternBytes));
            if (k < int'(len_next)) begin
                cell_pat_next[k] = pat_bytes[pi];
                cell_cmp_next[k] = mask_reg[pi];
            end else begin
                cell_pat_next[k] = 8'h00;
                cell_cmp_next[k] = 1'b0;
            end
        end
        base_off_next = base_reg + {{(AddrBits-OffsetBits){offset_reg[OffsetBits-1]}},
                                    offset_reg};
    end

    always_ff @(posedge aclk) begin
        len_reg      <= len_next;
        cell_pat_reg <= cell_pat_next;
        cell_cmp_reg <= cell_cmp_next;
        base_off_reg <= base_off_next;
    end

    // pipeline control
    logic skid_valid_reg;
    logic en;
    logic accept;

    assign en       = !skid_valid_reg;
    assign s_tready = en;
    assign accept   = s_tvalid && en;

    // cell row
    logic                              restart_reg;
    logic [MAX_PATTERN_BYTES-1:0][7:0] window;
    logic [MAX_PATTERN_BYTES-1:0]      hits;

    for (genvar k = 0; k < MAX_PATTERN_BYTES; k++) begin : g_cell
        logic [7:0] cell_in;
        cell_ctrl_t ctrl;
        if (k == 0) begin : g_head
            assign cell_in = s_tdata;
        end else begin : g_body
            assign cell_in = restart_reg ? 8'h00 : window[k-1];
        end
        assign ctrl.advance = accept;
        assign ctrl.cmp_en  = cell_cmp_reg[k];
        mbps_cell u_cell (
            .aclk     (aclk),
            .ctrl     (ctrl),
            .byte_in  (cell_in),
            .pat_byte (cell_pat_reg[k]),
            .byte_out (window[k]),
            .hit      (hits[k])
        );
    end

    // stage 1: byte count and region flags alongside the cell row
    logic                  s1_valid_reg;
    logic                  s1_last_reg;
    logic [INDEX_BITS-1:0] count_reg;
    logic [INDEX_BITS-1:0] count_next;

    always_comb begin
        if (restart_reg) begin
            count_next = INDEX_BITS'(1);
        end else if (&count_reg) begin
            count_next = count_reg;
        end else begin
            count_next = count_reg + INDEX_BITS'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            restart_reg  <= 1'b1;
            count_reg    <= '0;
        end else if (en) begin
            s1_valid_reg <= s_tvalid;
            if (s_tvalid) begin
                restart_reg <= s_tlast;
                count_reg   <= count_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_last_reg <= s_tlast;
        end
    end

    // stage 2: match decision
    logic                  done_reg;
    logic                  r2_valid_reg;
    logic                  r2_found_reg;
    logic [INDEX_BITS-1:0] r2_index_reg;
    logic                  match;
    logic                  miss;

    assign match = s1_valid_reg && !done_reg && (&hits)
                && (count_reg >= INDEX_BITS'(len_reg));
    assign miss  = s1_valid_reg && s1_last_reg && !done_reg && !match;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            done_reg     <= 1'b0;
            r2_valid_reg <= 1'b0;
        end else if (en) begin
            r2_valid_reg <= match || miss;
            if (s1_valid_reg) begin
                if (s1_last_reg) begin
                    done_reg <= 1'b0;
                end else if (match) begin
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            r2_found_reg <= match;
            r2_index_reg <= count_reg - INDEX_BITS'(len_reg);
        end
    end

    // stage 3: address add, output register and skid entry
    logic                out_valid_reg;
    logic                out_valid_next;
    logic                out_found_reg;
    logic                out_found_next;
    logic [AddrBits-1:0] out_addr_reg;
    logic [AddrBits-1:0] out_addr_next;
    logic                skid_valid_next;
    logic                skid_found_reg;
    logic                skid_found_next;
    logic [AddrBits-1:0] skid_addr_reg;
    logic [AddrBits-1:0] skid_addr_next;
    logic [AddrBits-1:0] new_addr;
    logic                take;

    assign new_addr = r2_found_reg ? (base_off_reg + AddrBits'(r2_index_reg)) : '0;
    assign take     = out_valid_reg && m_tready;

    always_comb begin
        out_valid_next  = out_valid_reg;
        out_found_next  = out_found_reg;
        out_addr_next   = out_addr_reg;
        skid_valid_next = skid_valid_reg;
        skid_found_next = skid_found_reg;
        skid_addr_next  = skid_addr_reg;
        if (en && r2_valid_reg) begin
            if (!out_valid_reg || take) begin
                out_valid_next = 1'b1;
                out_found_next = r2_found_reg;
                out_addr_next  = new_addr;
            end else begin
                skid_valid_next = 1'b1;
                skid_found_next = r2_found_reg;
                skid_addr_next  = new_addr;
            end
        end else if (take) begin
            if (skid_valid_reg) begin
                out_found_next  = skid_found_reg;
                out_addr_next   = skid_addr_reg;
                skid_valid_next = 1'b0;
            end else begin
                out_valid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_found_reg  <= out_found_next;
        out_addr_reg   <= out_addr_next;
        skid_found_reg <= skid_found_next;
        skid_addr_reg  <= skid_addr_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_addr_reg;
    assign m_tuser  = out_found_reg;

endmodule

[sv/mbps_checker.sv]
// Port-level checks for the masked byte pattern scan, bound to the top level.
module mbps_checker
    import mbps_pkg::*;
(
    input logic                aclk,
    input logic                aresetn,
    input logic                s_tready,
    input logic                m_tvalid,
    input logic                m_tready,
    input logic [AddrBits-1:0] m_tdata,
    input logic                m_tuser
);

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    a_miss_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> m_tdata == '0)
        else $error("not-found result with nonzero address");

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid && s_tready)
        else $error("result or stall right after reset");

    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> m_tvalid)
        else $error("input stalled with no result waiting");

endmodule

bind masked_byte_pattern_scan mbps_checker u_mbps_checker (.*);

[dv/tb.sv]
`timescale 1ns / 100ps
// Self-checking testbench for the masked byte pattern scan: scoreboard class and stream drivers.
module tb;
    import mbps_pkg::*;

    localparam int CycleLimit   = 400000;
    localparam int SettleCycles = 8;
    localparam int HoldCycles   = 80;
    localparam int RandomItems  = 950;

    typedef struct packed {
        logic                found;
        logic [AddrBits-1:0] addr;
    } scan_result_t;

    class scan_scoreboard;
        logic [63:0]           pattern_lo;
        logic [63:0]           pattern_hi;
        logic [MaskBits-1:0]   mask;
        logic [LengthBits-1:0] length;
        logic [AddrBits-1:0]   base;
        logic [OffsetBits-1:0] offset;
        logic [7:0]            window [PatternBytes];
        logic [31:0]           seen;
        logic                  done;
        scan_result_t          expected_q [$];
        int                    errors;
        int                    hits;
        int                    misses;

        function new();
            pattern_lo = '0;
            pattern_hi = '0;
            mask       = '0;
            length     = 5'd1;
            base       = '0;
            offset     = '0;
            errors     = 0;
            hits       = 0;
            misses     = 0;
            clear_region();
        endfunction

        function void clear_region();
            foreach (window[k]) window[k] = 8'h00;
            seen = '0;
            done = 1'b0;
        endfunction

        function int eff_length();
            int len;
            len = length;
            if (len < 1) len = 1;
            if (len > PatternBytes) len = PatternBytes;
            return len;
        endfunction

        function logic [7:0] pattern_byte(int i);
            logic [127:0] p;
            p = {pattern_hi, pattern_lo};
            return p[i*8 +: 8];
        endfunction

        function void write_reg(cfg_index_t idx, logic [63:0] v);
            case (idx)
                CFG_PATTERN_LOW:    pattern_lo = v;
                CFG_PATTERN_HIGH:   pattern_hi = v;
                CFG_COMPARE_MASK:   mask = v[MaskBits-1:0];
                CFG_PATTERN_LENGTH: length = v[LengthBits-1:0];
                CFG_REGION_BASE:    base = v;
                CFG_RESULT_OFFSET:  offset = v[OffsetBits-1:0];
                default: ;
            endcase
        endfunction

        function void note_request(logic [7:0] b, logic l);
            int           len;
            logic         hit;
            logic [63:0]  start_index;
            scan_result_t res;
            if (!done) begin
                len = eff_length();
                for (int k = PatternBytes - 1; k > 0; k--) window[k] = window[k-1];
                window[0] = b;
                if (seen != 32'hFFFF_FFFF) seen++;
                if (seen >= len) begin
                    hit = 1'b1;
                    for (int i = 0; i < len; i++) begin
                        if (mask[i] && window[len-1-i] != pattern_byte(i)) hit = 1'b0;
                    end
                    if (hit) begin
                        done        = 1'b1;
                        start_index = 64'(seen) - 64'(len);
                        res.found   = 1'b1;
                        res.addr    = base + start_index + {{32{offset[31]}}, offset};
                        expected_q.push_back(res);
                    end
                end
            end
            if (l) begin
                if (!done) begin
                    res.found = 1'b0;
                    res.addr  = '0;
                    expected_q.push_back(res);
                end
                clear_region();
            end
        endfunction

        function void report(string what, logic [63:0] exp_v, logic [63:0] act_v);
            errors++;
            $display("%0t: %s mismatch, expected %h, actual %h", $time, what,
                     exp_v, act_v);
        endfunction

        function void check_result(logic found, logic [AddrBits-1:0] addr);
            scan_result_t exp_r;
            if (expected_q.size() == 0) begin
                report("unexpected result", 64'h0, addr);
                return;
            end
            exp_r = expected_q.pop_front();
            if (found !== exp_r.found) report("found", 64'(exp_r.found), 64'(found));
            if (addr !== exp_r.addr) report("match_address", exp_r.addr, addr);
            if (exp_r.found) hits++;
            else misses++;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic                    aclk = 1'b0;
    logic                    aresetn;
    logic                    cfg_we;
    logic [CfgIndexBits-1:0] cfg_index;
    logic [CfgDataBits-1:0]  cfg_wdata;
    logic                    s_tvalid;
    logic                    s_tready;
    logic [7:0]              s_tdata;   // data_byte
    logic                    s_tlast;   // last_byte
    logic                    m_tvalid;
    logic                    m_tready;
    logic [AddrBits-1:0]     m_tdata;   // match_address
    logic                    m_tuser;   // found

    scan_scoreboard sb = new();
    int cycles = 0;
    int requests;
    int settings_count;
    bit tx_gaps_on;
    bit hold_pending;
    bit pressure_done;

    masked_byte_pattern_scan dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles >= CycleLimit) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    task automatic send_item(logic [7:0] b, logic l);
        int gap;
        gap = tx_gaps_on ? $urandom_range(0, 3) : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= l;
        do @(posedge aclk); while (!s_tready);
        sb.note_request(b, l);
        requests++;
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (SettleCycles) @(posedge aclk);
    endtask

    task automatic put_reg(cfg_index_t idx, logic [63:0] v);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= v;
        @(posedge aclk);
        sb.write_reg(idx, v);
    endtask

    task automatic load_settings(logic [63:0] lo, logic [63:0] hi, logic [63:0] mk,
                                 logic [63:0] ln, logic [63:0] bs, logic [63:0] of);
        put_reg(CFG_PATTERN_LOW, lo);
        put_reg(CFG_PATTERN_HIGH, hi);
        put_reg(CFG_COMPARE_MASK, mk);
        put_reg(CFG_PATTERN_LENGTH, ln);
        put_reg(CFG_REGION_BASE, bs);
        put_reg(CFG_RESULT_OFFSET, of);
        cfg_we <= 1'b0;
        settings_count++;
    endtask

    task automatic random_settings();
        logic [63:0] lo, hi, bs, junk;
        logic [15:0] m16;
        logic [4:0]  l5;
        logic [31:0] o32;
        case ($urandom_range(0, 5))
            0: lo = '0;
            1: lo = '1;
            default: lo = {$urandom, $urandom};
        endcase
        case ($urandom_range(0, 5))
            0: hi = '0;
            1: hi = '1;
            default: hi = {$urandom, $urandom};
        endcase
        case ($urandom_range(0, 3))
            0: m16 = 16'hFFFF;
            1: m16 = 16'h0000;
            default: m16 = 16'($urandom);
        endcase
        case ($urandom_range(0, 7))
            0: l5 = 5'd0;
            1: l5 = 5'($urandom_range(17, 31));
            2: l5 = 5'd16;
            3: l5 = 5'd1;
            default: l5 = 5'($urandom_range(1, 16));
        endcase
        case ($urandom_range(0, 4))
            0: bs = '0;
            1: bs = '1;
            default: bs = {$urandom, $urandom};
        endcase
        case ($urandom_range(0, 5))
            0: o32 = 32'h0000_0000;
            1: o32 = 32'h8000_0000;
            2: o32 = 32'h7FFF_FFFF;
            3: o32 = 32'hFFFF_FFFF;
            default: o32 = $urandom;
        endcase
        junk = ($urandom_range(0, 3) == 0) ? {$urandom, $urandom} : 64'h0;
        load_settings(lo, hi, {junk[63:16], m16}, {junk[63:5], l5}, bs, {junk[63:32], o32});
    endtask

    task automatic send_region(int nbytes, bit plant, bit close);
        logic [7:0] region_bytes [$];
        int         len;
        int         pos;
        len = sb.eff_length();
        for (int j = 0; j < nbytes; j++) begin
            if ($urandom_range(0, 3) == 0)
                region_bytes.push_back(sb.pattern_byte($urandom_range(0, len - 1)));
            else
                region_bytes.push_back(8'($urandom));
        end
        if (plant && nbytes >= len) begin
            pos = $urandom_range(0, nbytes - len);
            for (int i = 0; i < len; i++) begin
                if (sb.mask[i]) region_bytes[pos+i] = sb.pattern_byte(i);
            end
        end
        for (int j = 0; j < nbytes; j++) send_item(region_bytes[j], close && j == nbytes - 1);
    endtask

    initial begin
        int  wait_n;
        int  stretch;
        bit  stall_on;
        m_tready <= 1'b0;
        stretch  = 0;
        stall_on = 1'b1;
        wait (aresetn === 1'b1);
        @(posedge aclk);
        forever begin
            if (stretch == 0) begin
                stretch  = $urandom_range(1, 40);
                stall_on = ($urandom_range(0, 2) != 0);
            end
            stretch--;
            wait_n = stall_on ? $urandom_range(0, 3) : 0;
            if (hold_pending) begin
                hold_pending = 1'b0;
                wait_n = HoldCycles;
            end
            if (wait_n > 0) begin
                m_tready <= 1'b0;
                repeat (wait_n) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            sb.check_result(m_tuser, m_tdata);
        end
    end

    initial begin
        int n_regions;
        int nb;
        bit close;
        aresetn   <= 1'b0;
        cfg_we    <= 1'b0;
        cfg_index <= CFG_PATTERN_LOW;
        cfg_wdata <= '0;
        s_tvalid  <= 1'b0;
        s_tdata   <= 8'h00;
        s_tlast   <= 1'b0;
        tx_gaps_on    = 1'b1;
        hold_pending  = 1'b0;
        pressure_done = 1'b0;
        requests       = 0;
        settings_count = 0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset settings: one wildcard byte, match at address zero
        send_item(8'h00, 1'b1);

        drain();
        load_settings(64'hA5A5_A5A5_A5A5_00FF, '1, 64'h3, 64'd2, '1, 64'hFFFF_FFFF);
        send_item(8'h00, 1'b1);
        send_item(8'hFF, 1'b0);
        send_item(8'h00, 1'b1);
        send_item(8'hFF, 1'b0);
        send_item(8'h00, 1'b0);
        send_item(8'hFF, 1'b1);

        drain();
        load_settings(64'hFF, 64'h0, 64'h1, 64'd0, 64'h0, 64'h7FFF_FFFF);
        send_item(8'h12, 1'b0);
        send_item(8'hFF, 1'b0);
        send_item(8'h34, 1'b1);

        drain();
        load_settings(64'h0706_0504_0302_0100, 64'h0F0E_0D0C_0B0A_0908, 64'h8001, 64'd31,
                      64'h8000_0000, 64'h8000_0000);
        for (int i = 0; i < 16; i++) send_item(8'(i), i == 15);

        while (requests < RandomItems) begin
            drain();
            random_settings();
            tx_gaps_on = ($urandom_range(0, 3) != 0);
            n_regions  = $urandom_range(3, 8);
            for (int r = 0; r < n_regions; r++) begin
                nb    = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 64) : $urandom_range(1, 20);
                close = !(r == n_regions - 1 && $urandom_range(0, 4) == 0);
                send_region(nb, $urandom_range(0, 4) < 3, close);
            end
            if (!pressure_done && requests > RandomItems / 2) begin
                drain();
                hold_pending = 1'b1;
                tx_gaps_on   = 1'b0;
                repeat (40) send_item(8'($urandom), 1'b1);
                pressure_done = 1'b1;
            end
        end
        tx_gaps_on = 1'b1;
        send_item(8'($urandom), 1'b1);
        drain();

        $display("Summary: %0d bytes over %0d register settings, %0d found and %0d not-found",
                 requests, settings_count, sb.hits, sb.misses);
        if (sb.errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
